@@ rtl/core/sdc_pkg.sv @@
// Package for the scaled decimal compare: widths, relation codes and the scaling step table.
`timescale 1ns / 1ps

package sdc_pkg;

  // Operand field widths
  localparam int CMD_W       = 3;
  localparam int MANT_LOW_W  = 64;
  localparam int MANT_HIGH_W = 32;
  localparam int MANT_W      = MANT_LOW_W + MANT_HIGH_W;
  localparam int SCALE_W     = 5;

  // Largest scale; larger codes saturate to it
  localparam logic [SCALE_W-1:0] MAX_SCALE = 5'd28;

  // Aligned magnitude: 96-bit mantissa times up to 10^28 stays below 2^192
  localparam int MAG_W = 2 * MANT_W;

  // Each multiply stage removes up to two decimal digits of scale difference
  localparam int               STEP_DIGITS = 2;
  localparam int               FACTOR_W    = 7;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE     = 7'd1;
  localparam logic [FACTOR_W-1:0] FACTOR_TEN     = 7'd10;
  localparam logic [FACTOR_W-1:0] FACTOR_HUNDRED = 7'd100;
  localparam int MUL_STAGES = (int'(MAX_SCALE) + STEP_DIGITS - 1) / STEP_DIGITS;

  // Words in flight: input stage, multiply stages, compare stage, output register
  localparam int PIPE_DEPTH = MUL_STAGES + 3;
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

  // Relation codes
  localparam logic [CMD_W-1:0] CMD_GT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EQ = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LE = 3'd5;

  // Control that rides along with the magnitudes
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             a_neg;
    logic             b_neg;
    logic             x_is_b;    // the scaled operand came from b
    logic             both_zero;
  } ctl_t;

  // Saturate a scale code to the legal range
  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] s);
    return (s > MAX_SCALE) ? MAX_SCALE : s;
  endfunction

  // Multiplier for one stage given the digits still to scale
  function automatic logic [FACTOR_W-1:0] step_factor(input logic [SCALE_W-1:0] r);
    logic [FACTOR_W-1:0] f;
    if (r >= SCALE_W'(STEP_DIGITS)) begin
      f = FACTOR_HUNDRED;
    end else if (r == SCALE_W'(1)) begin
      f = FACTOR_TEN;
    end else begin
      f = FACTOR_ONE;
    end
    return f;
  endfunction

  // Digits left after one stage
  function automatic logic [SCALE_W-1:0] step_rem(input logic [SCALE_W-1:0] r);
    return (r >= SCALE_W'(STEP_DIGITS)) ? (r - SCALE_W'(STEP_DIGITS)) : '0;
  endfunction

endpackage

@@ rtl/core/scaled_decimal_compare.sv @@
// Throughput: one word per cycle while the output is not stalled; the depth is set by the input
// stage and the 14 multiply stages (by 100, 10 or 1) that align the smaller-scale mantissa,
// plus one compare stage and the output register, which drives relation_true.
// An output stall freezes the whole pipeline and raises in_stall in the same cycle.
// Reset (rst, synchronous, active high) clears all valid bits; no result is pending after it.
`timescale 1ns / 1ps

module scaled_decimal_compare (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sdc_pkg::CMD_W-1:0]       cmd,
  input  logic [sdc_pkg::MANT_LOW_W-1:0]  a_mant_low,
  input  logic [sdc_pkg::MANT_HIGH_W-1:0] a_mant_high,
  input  logic [sdc_pkg::SCALE_W-1:0]     a_scale,
  input  logic                            a_negative,
  input  logic [sdc_pkg::MANT_LOW_W-1:0]  b_mant_low,
  input  logic [sdc_pkg::MANT_HIGH_W-1:0] b_mant_high,
  input  logic [sdc_pkg::SCALE_W-1:0]     b_scale,
  input  logic                            b_negative,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            relation_true
);
  import sdc_pkg::*;

  logic                  adv;
  logic [SCALE_W-1:0]    sa, sb;
  logic [MANT_W-1:0]     a_mag, b_mag;
  logic                  a_small;
  logic [MAG_W-1:0]      x_in;
  logic [MANT_W-1:0]     y_in;
  logic [SCALE_W-1:0]    rem_in;
  ctl_t                  ctl_in;

  logic                  vld  [0:MUL_STAGES];
  logic [MAG_W-1:0]      xm   [0:MUL_STAGES];
  logic [MANT_W-1:0]     ym   [0:MUL_STAGES];
  logic [SCALE_W-1:0]    rem  [0:MUL_STAGES];
  ctl_t                  ctl  [0:MUL_STAGES];
  logic [MAG_W-1:0]      xm_next  [0:MUL_STAGES-1];
  logic [SCALE_W-1:0]    rem_next [0:MUL_STAGES-1];

  logic                  cmp_vld;
  logic                  cmp_gt, cmp_eq;
  ctl_t                  cmp_ctl;
  logic                  ord_gt, ord_eq, ord_lt;
  logic                  mag_a_gt, mag_a_lt;
  logic                  relation_next;

  // Whole pipeline moves unless the output word is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Input alignment: pick the operand with the smaller scale for scaling
  always_comb begin
    sa      = clamp_scale(a_scale);
    sb      = clamp_scale(b_scale);
    a_mag   = {a_mant_high, a_mant_low};
    b_mag   = {b_mant_high, b_mant_low};
    a_small = (sa < sb);
    if (a_small) begin
      x_in   = {{(MAG_W-MANT_W){1'b0}}, a_mag};
      y_in   = b_mag;
      rem_in = sb - sa;
    end else begin
      x_in   = {{(MAG_W-MANT_W){1'b0}}, b_mag};
      y_in   = a_mag;
      rem_in = sa - sb;
    end
    ctl_in.cmd       = cmd;
    ctl_in.a_neg     = a_negative;
    ctl_in.b_neg     = b_negative;
    ctl_in.x_is_b    = !a_small;
    ctl_in.both_zero = (a_mag == '0) && (b_mag == '0);
  end

  // Scaling stages: multiply by 100, 10 or 1 as sums of shifted copies
  always_comb begin
    for (int k = 0; k < MUL_STAGES; k++) begin
      case (step_factor(rem[k]))
        FACTOR_HUNDRED: xm_next[k] = (xm[k] << 6) + (xm[k] << 5) + (xm[k] << 2);
        FACTOR_TEN:     xm_next[k] = (xm[k] << 3) + (xm[k] << 1);
        default:        xm_next[k] = xm[k];
      endcase
      rem_next[k] = step_rem(rem[k]);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= MUL_STAGES; k++) begin
        vld[k] <= 1'b0;
      end
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 0; k < MUL_STAGES; k++) begin
        vld[k+1] <= vld[k];
      end
      cmp_vld   <= vld[MUL_STAGES];
      out_valid <= cmp_vld;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      xm[0]  <= x_in;
      ym[0]  <= y_in;
      rem[0] <= rem_in;
      ctl[0] <= ctl_in;
      for (int k = 0; k < MUL_STAGES; k++) begin
        xm[k+1]  <= xm_next[k];
        ym[k+1]  <= ym[k];
        rem[k+1] <= rem_next[k];
        ctl[k+1] <= ctl[k];
      end
      cmp_gt        <= xm[MUL_STAGES] > {{(MAG_W-MANT_W){1'b0}}, ym[MUL_STAGES]};
      cmp_eq        <= xm[MUL_STAGES] == {{(MAG_W-MANT_W){1'b0}}, ym[MUL_STAGES]};
      cmp_ctl       <= ctl[MUL_STAGES];
      relation_true <= relation_next;
    end
  end

  // Signed order of a against b
  always_comb begin
    mag_a_gt = cmp_ctl.x_is_b ? (!cmp_gt && !cmp_eq) : cmp_gt;
    mag_a_lt = cmp_ctl.x_is_b ? cmp_gt : (!cmp_gt && !cmp_eq);
    if (cmp_ctl.both_zero) begin
      ord_gt = 1'b0;
      ord_lt = 1'b0;
    end else if (cmp_ctl.a_neg != cmp_ctl.b_neg) begin
      ord_gt = !cmp_ctl.a_neg;
      ord_lt = cmp_ctl.a_neg;
    end else if (cmp_ctl.a_neg) begin
      ord_gt = mag_a_lt;
      ord_lt = mag_a_gt;
    end else begin
      ord_gt = mag_a_gt;
      ord_lt = mag_a_lt;
    end
    ord_eq = !ord_gt && !ord_lt;
  end

  // Relation select; unused codes give false
  always_comb begin
    unique case (cmp_ctl.cmd)
      CMD_GT:  relation_next = ord_gt;
      CMD_EQ:  relation_next = ord_eq;
      CMD_NE:  relation_next = !ord_eq;
      CMD_GE:  relation_next = !ord_lt;
      CMD_LT:  relation_next = ord_lt;
      CMD_LE:  relation_next = !ord_gt;
      default: relation_next = 1'b0;
    endcase
  end

endmodule

@@ rtl/core/sdc_checker.sv @@
// Port-level checks for the scaled decimal compare, bound to the top level.
`timescale 1ns / 1ps

module sdc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic relation_true
);
  import sdc_pkg::*;

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] outstanding;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // A held output word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(relation_true))
    else $error("output word changed while stalled");

  // The input is only held back when the output word is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // No word is delivered that was not accepted earlier
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> outstanding != '0)
    else $error("result delivered with no word in flight");

  // Never more words in flight than pipeline places
  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CNT_W'(PIPE_DEPTH))
    else $error("more words in flight than pipeline depth");

endmodule

bind scaled_decimal_compare sdc_checker u_sdc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .relation_true (relation_true)
);
